// ===== src/assert_macros.svh =====
// Assertion macros for the RTL of the gas level alarm detector.
// No dependencies; the macros are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/gald_pkg.sv =====
// Package of the gas level alarm detector: widths, constants, register
// indexes and the result struct. No dependencies.
`default_nettype none
package gald_pkg;

  localparam int ADC_W      = 12;
  localparam int OFFSET_W   = 12;
  localparam int WARM_W     = 20;
  localparam int ALARM_W    = 8;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 1;

  localparam int CAL_SAMPLES_DEF = 64;

  localparam logic [OFFSET_W-1:0] ALARM_OFFSET_RST = 12'd300;
  localparam logic [WARM_W-1:0]   WARMUP_TICKS_RST = 20'd60000;

  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_TICKS = 1'b1;

  localparam int GROUP_SIZE = 5;
  localparam int GRP_CNT_W  = 3;
  localparam int GRP_SUM_W  = 15;
  localparam int GRP_SHIFT  = 18;
  localparam int GRP_RECIP  = ((1 << GRP_SHIFT) + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GRP_PROD_W = GRP_SUM_W + 16;

  localparam logic [ALARM_W-1:0] DANGER_LEVEL = 8'd3;
  localparam logic [ALARM_W-1:0] ALARM_MAX    = 8'd255;

  typedef struct packed {
    logic              average_new;
    logic [ADC_W-1:0]  last_average;
    logic [ADC_W-1:0]  base_level;
    logic              sensor_ready;
    logic              danger;
  } gald_result_t;

endpackage
`default_nettype wire

// ===== src/gald_engine.sv =====
// Detector state and per-item step logic: warm-up, baseline calibration,
// five-sample averaging and the danger counter. Depends on gald_pkg.
`default_nettype none
module gald_engine
  import gald_pkg::*;
#(
  parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                commit,
  input  wire logic                cmd,
  input  wire logic [ADC_W-1:0]    sample,
  input  wire logic [OFFSET_W-1:0] alarm_offset,
  input  wire logic [WARM_W-1:0]   warmup_ticks,
  output gald_result_t             result
);

  localparam int CAL_LOG     = $clog2(CAL_SAMPLES);
  localparam int CAL_CNT_W   = (CAL_LOG < 1) ? 1 : CAL_LOG;
  localparam int CAL_SUM_W   = ADC_W + CAL_LOG;
  localparam int CAL_SHIFT   = ADC_W + 2 * CAL_LOG;
  localparam int CAL_RECIP_W = CAL_SHIFT - CAL_LOG + 1;
  localparam int CAL_PROD_W  = CAL_SUM_W + CAL_RECIP_W;
  localparam int CAL_RECIP   = ((1 << CAL_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam int CAL_LAST    = CAL_SAMPLES - 1;

  typedef enum logic [1:0] {
    PH_WARM = 2'd0,
    PH_CAL  = 2'd1,
    PH_RUN  = 2'd2
  } phase_t;

  phase_t                 phase_r, phase_nxt, phase_eff;
  logic [WARM_W-1:0]      warm_count_r, warm_count_nxt;
  logic [CAL_CNT_W-1:0]   cal_count_r, cal_count_nxt;
  logic [CAL_SUM_W-1:0]   cal_sum_r, cal_sum_nxt, cal_add;
  logic [ADC_W-1:0]       baseline_r, baseline_nxt;
  logic [GRP_CNT_W-1:0]   group_count_r, group_count_nxt;
  logic [GRP_SUM_W-1:0]   group_sum_r, group_sum_nxt, grp_add;
  logic [ALARM_W-1:0]     alarm_count_r, alarm_count_nxt;
  logic [ADC_W-1:0]       recent_r, recent_nxt;
  logic                   fresh;
  logic                   running;
  logic [CAL_PROD_W-1:0]  cal_prod;
  logic [GRP_PROD_W-1:0]  grp_prod;
  logic [ADC_W-1:0]       grp_avg;
  logic [ADC_W:0]         thresh;

  assign cal_add  = cal_sum_r + CAL_SUM_W'(sample);
  assign cal_prod = CAL_PROD_W'(cal_add) * CAL_PROD_W'(CAL_RECIP);
  assign grp_add  = group_sum_r + GRP_SUM_W'(sample);
  assign grp_prod = GRP_PROD_W'(grp_add) * GRP_PROD_W'(GRP_RECIP);
  assign grp_avg  = grp_prod[GRP_SHIFT +: ADC_W];
  assign thresh   = {1'b0, baseline_r} + {1'b0, alarm_offset};

  always_comb begin
    phase_nxt       = phase_r;
    warm_count_nxt  = warm_count_r;
    cal_count_nxt   = cal_count_r;
    cal_sum_nxt     = cal_sum_r;
    baseline_nxt    = baseline_r;
    group_count_nxt = group_count_r;
    group_sum_nxt   = group_sum_r;
    alarm_count_nxt = alarm_count_r;
    recent_nxt      = recent_r;
    fresh           = 1'b0;

    phase_eff = phase_r;
    if (phase_r == PH_WARM && warm_count_r >= warmup_ticks) begin
      phase_eff = PH_CAL;
    end
    phase_nxt = phase_eff;

    case (phase_eff)
      PH_WARM: begin
        if (!cmd && warm_count_r != '1) begin
          warm_count_nxt = warm_count_r + 1'b1;
        end
        if (warm_count_nxt >= warmup_ticks) begin
          phase_nxt = PH_CAL;
        end
      end
      PH_CAL: begin
        if (cmd) begin
          if (cal_count_r == CAL_CNT_W'(CAL_LAST)) begin
            baseline_nxt  = cal_prod[CAL_SHIFT +: ADC_W];
            cal_count_nxt = '0;
            cal_sum_nxt   = '0;
            phase_nxt     = PH_RUN;
          end else begin
            cal_sum_nxt   = cal_add;
            cal_count_nxt = cal_count_r + 1'b1;
          end
        end
      end
      default: begin
        if (cmd) begin
          if (group_count_r == GRP_CNT_W'(GROUP_SIZE - 1)) begin
            recent_nxt      = grp_avg;
            group_sum_nxt   = '0;
            group_count_nxt = '0;
            fresh           = 1'b1;
            if ({1'b0, grp_avg} >= thresh) begin
              if (alarm_count_r != ALARM_MAX) begin
                alarm_count_nxt = alarm_count_r + 1'b1;
              end
            end else if (alarm_count_r != '0) begin
              alarm_count_nxt = alarm_count_r - 1'b1;
            end
          end else begin
            group_sum_nxt   = grp_add;
            group_count_nxt = group_count_r + 1'b1;
          end
        end
      end
    endcase

    running = (phase_nxt != PH_WARM) && (phase_nxt != PH_CAL);

    result.danger       = running && (alarm_count_nxt >= DANGER_LEVEL);
    result.sensor_ready = running;
    result.base_level   = baseline_nxt;
    result.last_average = recent_nxt;
    result.average_new  = fresh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_WARM;
      warm_count_r  <= '0;
      cal_count_r   <= '0;
      cal_sum_r     <= '0;
      baseline_r    <= '0;
      group_count_r <= '0;
      group_sum_r   <= '0;
      alarm_count_r <= '0;
      recent_r      <= '0;
    end else if (commit) begin
      phase_r       <= phase_nxt;
      warm_count_r  <= warm_count_nxt;
      cal_count_r   <= cal_count_nxt;
      cal_sum_r     <= cal_sum_nxt;
      baseline_r    <= baseline_nxt;
      group_count_r <= group_count_nxt;
      group_sum_r   <= group_sum_nxt;
      alarm_count_r <= alarm_count_nxt;
      recent_r      <= recent_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/gas_level_alarm_detector_core.sv =====
// Top level of the gas level alarm detector: stream ports, input and result
// registers, configuration registers. Depends on gald_pkg and gald_engine.
//
//   channel  dir  handshake            payload
//   in       in   in_tvalid/in_tready  in_tuser = cmd, in_tdata = adc_sample
//   out      out  out_tvalid/out_tready out_tdata = result fields
//   cfg      in   cfg_we               cfg_index, cfg_wdata
//
// Every item yields one result; one item per cycle is sustained while out_tready
// is high. An item taken into the input register is stepped into the result
// register when it advances, and its result is then offered on the out channel.
// While a result waits on out_tready the input register takes at most one more
// item, then in_tready stays low until the result is taken. Synchronous active-low
// reset returns the detector to warm-up and the config registers to defaults.
`default_nettype none
`include "assert_macros.svh"
module gas_level_alarm_detector_core
  import gald_pkg::*;
#(
  parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [0] cmd
  input  wire logic                  in_tuser,
  // [11:0] adc_sample, [15:12] zero
  input  wire logic [15:0]           in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] danger, [1] sensor_ready, [13:2] base_level, [25:14] last_average,
  // [26] average_new, [31:27] zero
  output logic [31:0]                out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic                s1_valid_r;
  logic                s1_cmd_r;
  logic [ADC_W-1:0]    s1_sample_r;
  logic                out_valid_r;
  gald_result_t        out_res_r;
  gald_result_t        step_res;
  logic                advance;
  logic [OFFSET_W-1:0] alarm_offset_r;
  logic [WARM_W-1:0]   warmup_ticks_r;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  gald_engine #(
    .CAL_SAMPLES(CAL_SAMPLES)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .commit       (advance),
    .cmd          (s1_cmd_r),
    .sample       (s1_sample_r),
    .alarm_offset (alarm_offset_r),
    .warmup_ticks (warmup_ticks_r),
    .result       (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r    <= in_tuser;
      s1_sample_r <= in_tdata[ADC_W-1:0];
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_offset_r <= ALARM_OFFSET_RST;
      warmup_ticks_r <= WARMUP_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALARM_OFFSET: alarm_offset_r <= cfg_wdata[OFFSET_W-1:0];
        CFG_WARMUP_TICKS: warmup_ticks_r <= cfg_wdata[WARM_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r};

  `ASSERT_IMPLIES(a_danger_ready, clk, rst_n, out_valid_r && out_res_r.danger, out_res_r.sensor_ready, "danger without calibration")
  `ASSERT_IMPLIES(a_avg_ready, clk, rst_n, out_valid_r && out_res_r.average_new, out_res_r.sensor_ready, "average before calibration")
  `ASSERT_IMPLIES(a_base_zero, clk, rst_n, out_valid_r && !out_res_r.sensor_ready, out_res_r.base_level == '0, "baseline set before calibration")
  `ASSERT_NEXT(a_advance_out, clk, rst_n, advance, out_valid_r, "advanced item lost")

endmodule
`default_nettype wire
